// File: rtl/ttb_pkg.sv
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared types and constants of the triangle tile binner.
// ----------------------------------------------------------------------------
`default_nettype none

package ttb_pkg;

  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int COORD_W     = 16;
  localparam int TRI_W       = 16;
  localparam int TILE_W      = 6;
  localparam int TILE_IDX_W  = 3;
  localparam int QUOT_W      = 4;
  localparam int SHIFT_MAX   = 3;
  localparam int GRID_DIV_W  = CFG_W + 1;

  localparam logic [QUOT_W-1:0] QUOT_SAT = QUOT_W'(1 << SHIFT_MAX);

  localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET        = 2'd3;

  localparam logic [CFG_W-1:0] TILE_SIZE_RST     = 12'd64;
  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 12'd512;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 12'd512;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_WALK
  } state_t;

  typedef enum logic [2:0] {
    DS_GRID_X,
    DS_GRID_Y,
    DS_COL_LO,
    DS_ROW_LO,
    DS_COL_HI,
    DS_ROW_HI
  } div_sel_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/ttb_div.sv
// ----------------------------------------------------------------------------
// ttb_div
// Four-step compare-subtract divider, quotient saturated at eight.
// ----------------------------------------------------------------------------
`default_nettype none

module ttb_div #(
  parameter int DIV_W = 13
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [DIV_W-1:0]          dividend,
  input  logic [ttb_pkg::CFG_W-1:0] divisor,
  output ttb_pkg::div_rsp_t         rsp
);
  import ttb_pkg::*;

  localparam int CW = (DIV_W > CFG_W + SHIFT_MAX) ? DIV_W : CFG_W + SHIFT_MAX;

  logic             busy_r, busy_nxt;
  logic [1:0]       step_r, step_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [CFG_W-1:0] dsor_r, dsor_nxt;
  logic             sat_r, sat_nxt;
  logic [1:0]       qhi_r, qhi_nxt;

  logic [CW-1:0] shifted;
  logic [CW-1:0] diff;
  logic          ge;

  always_comb begin
    shifted = CW'(dsor_r) << step_r;
    ge      = CW'(rem_r) >= shifted;
    diff    = CW'(rem_r) - shifted;
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dsor_nxt = dsor_r;
    sat_nxt  = sat_r;
    qhi_nxt  = qhi_r;
    if (busy_r) begin
      unique case (step_r)
        2'd3: sat_nxt = ge;
        2'd2: begin
          qhi_nxt[1] = ge;
          if (ge) rem_nxt = diff[DIV_W-1:0];
        end
        2'd1: begin
          qhi_nxt[0] = ge;
          if (ge) rem_nxt = diff[DIV_W-1:0];
        end
        2'd0: busy_nxt = 1'b0;
        default: busy_nxt = 1'b0;
      endcase
      step_nxt = step_r - 2'd1;
    end
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = 2'(SHIFT_MAX);
      rem_nxt  = dividend;
      dsor_nxt = divisor;
      sat_nxt  = 1'b0;
      qhi_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    rem_r  <= rem_nxt;
    dsor_r <= dsor_nxt;
    sat_r  <= sat_nxt;
    qhi_r  <= qhi_nxt;
  end

  always_comb begin
    rsp.done = busy_r && (step_r == 2'd0);
    rsp.quot = sat_r ? QUOT_SAT : {1'b0, qhi_r, ge};
  end

endmodule

`default_nettype wire

// File: rtl/triangle_tile_binner.sv
// ----------------------------------------------------------------------------
// triangle_tile_binner
// Bins one triangle into every screen tile touched by its bounding box.
// ----------------------------------------------------------------------------
// A triangle is taken when in_ready is high; the block then holds in_ready
// low while it works. It takes the bounding box, runs six divisions in one
// shared compare-subtract divider (tile grid width and height, then the four
// box edges), checks the range, and then sends one tile per cycle (1 to 64
// covered tiles) while out_ready does not stall the result register. The
// next triangle is taken as soon as the last result sits in that register.
// Tiles leave row by row, left to right, the final one flagged by
// out_last_tile; a triangle off the grid, or no bound target, yields nothing.
`default_nettype none

module triangle_tile_binner #(
  parameter int MAX_TILES_X     = 8,
  parameter int MAX_TILES_Y     = 8,
  parameter int COORD_FRAC_BITS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ttb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ttb_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ttb_pkg::TRI_W-1:0]           in_triangle_id,
  input  logic signed [ttb_pkg::COORD_W-1:0]  in_vert0_x,
  input  logic signed [ttb_pkg::COORD_W-1:0]  in_vert0_y,
  input  logic signed [ttb_pkg::COORD_W-1:0]  in_vert1_x,
  input  logic signed [ttb_pkg::COORD_W-1:0]  in_vert1_y,
  input  logic signed [ttb_pkg::COORD_W-1:0]  in_vert2_x,
  input  logic signed [ttb_pkg::COORD_W-1:0]  in_vert2_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ttb_pkg::TILE_W-1:0]          out_tile_index,
  output logic [ttb_pkg::TRI_W-1:0]           out_binned_triangle,
  output logic                                out_last_tile
);
  import ttb_pkg::*;

  localparam int PX_W  = COORD_W + 1 - COORD_FRAC_BITS;
  localparam int MAG_W = PX_W - 1;
  localparam int DIV_W = (MAG_W > GRID_DIV_W) ? MAG_W : GRID_DIV_W;
  localparam int EXT_W = COORD_W + 1;
  localparam logic [EXT_W-1:0] FRAC_ROUND = EXT_W'((1 << COORD_FRAC_BITS) - 1);
  localparam logic [QUOT_W-1:0] MAX_X = QUOT_W'(MAX_TILES_X);
  localparam logic [QUOT_W-1:0] MAX_Y = QUOT_W'(MAX_TILES_Y);

  function automatic logic signed [PX_W-1:0] px_floor(input logic signed [COORD_W-1:0] v);
    logic signed [EXT_W-1:0] e;
    e = $signed({v[COORD_W-1], v});
    return PX_W'(e >>> COORD_FRAC_BITS);
  endfunction

  function automatic logic signed [PX_W-1:0] px_ceil(input logic signed [COORD_W-1:0] v);
    logic signed [EXT_W-1:0] e;
    e = $signed({v[COORD_W-1], v}) + $signed(FRAC_ROUND);
    return PX_W'(e >>> COORD_FRAC_BITS);
  endfunction

  function automatic logic [MAG_W-1:0] px_mag(input logic signed [PX_W-1:0] p);
    logic signed [PX_W-1:0] n;
    n = -p;
    return p[PX_W-1] ? MAG_W'(n) : MAG_W'(p);
  endfunction

  // configuration
  logic [CFG_W-1:0] tile_size_r, screen_width_r, screen_height_r;
  logic             target_present_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_size_r      <= TILE_SIZE_RST;
      screen_width_r   <= SCREEN_WIDTH_RST;
      screen_height_r  <= SCREEN_HEIGHT_RST;
      target_present_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TILE_SIZE:     tile_size_r      <= cfg_data;
        CFG_SCREEN_WIDTH:  screen_width_r   <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height_r  <= cfg_data;
        CFG_TARGET:        target_present_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [CFG_W-1:0]      ts_eff;
  logic [GRID_DIV_W-1:0] grid_x_num, grid_y_num;

  always_comb begin
    ts_eff     = (tile_size_r == '0) ? CFG_W'(1) : tile_size_r;
    grid_x_num = {1'b0, screen_width_r} + {1'b0, ts_eff} - GRID_DIV_W'(1);
    grid_y_num = {1'b0, screen_height_r} + {1'b0, ts_eff} - GRID_DIV_W'(1);
  end

  // bounding box
  logic signed [COORD_W-1:0] xmin, xmax, ymin, ymax, xa, ya, xb, yb;

  always_comb begin
    xa   = (in_vert0_x < in_vert1_x) ? in_vert0_x : in_vert1_x;
    xmin = (xa < in_vert2_x) ? xa : in_vert2_x;
    xb   = (in_vert0_x > in_vert1_x) ? in_vert0_x : in_vert1_x;
    xmax = (xb > in_vert2_x) ? xb : in_vert2_x;
    ya   = (in_vert0_y < in_vert1_y) ? in_vert0_y : in_vert1_y;
    ymin = (ya < in_vert2_y) ? ya : in_vert2_y;
    yb   = (in_vert0_y > in_vert1_y) ? in_vert0_y : in_vert1_y;
    ymax = (yb > in_vert2_y) ? yb : in_vert2_y;
  end

  // sequencer state and datapath registers
  state_t                state_r, state_nxt;
  div_sel_t              div_idx_r, div_idx_nxt;
  logic signed [PX_W-1:0] px_x0_r, px_x0_nxt, px_x1_r, px_x1_nxt;
  logic signed [PX_W-1:0] px_y0_r, px_y0_nxt, px_y1_r, px_y1_nxt;
  logic [TRI_W-1:0]      held_triangle_r, held_triangle_nxt;
  logic [QUOT_W-1:0]     tiles_x_r, tiles_x_nxt, tiles_y_r, tiles_y_nxt;
  logic [QUOT_W-1:0]     q_c0_r, q_c0_nxt, q_r0_r, q_r0_nxt;
  logic [QUOT_W-1:0]     q_c1_r, q_c1_nxt, q_r1_r, q_r1_nxt;
  logic [TILE_IDX_W-1:0] walk_col_r, walk_col_nxt, walk_row_r, walk_row_nxt;
  logic [TILE_IDX_W-1:0] col_first_r, col_first_nxt;
  logic [TILE_IDX_W-1:0] col_final_r, col_final_nxt, row_final_r, row_final_nxt;
  logic [TILE_W-1:0]     row_base_r, row_base_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [TILE_W-1:0]     out_tile_r, out_tile_nxt;
  logic [TRI_W-1:0]      out_tri_r, out_tri_nxt;
  logic                  out_last_r, out_last_nxt;

  // divider
  logic             div_start;
  div_sel_t         div_sel;
  logic [DIV_W-1:0] div_dividend;
  div_rsp_t         div_rsp;

  always_comb begin
    unique case (div_sel)
      DS_GRID_X: div_dividend = DIV_W'(grid_x_num);
      DS_GRID_Y: div_dividend = DIV_W'(grid_y_num);
      DS_COL_LO: div_dividend = DIV_W'(px_mag(px_x0_r));
      DS_ROW_LO: div_dividend = DIV_W'(px_mag(px_y0_r));
      DS_COL_HI: div_dividend = DIV_W'(px_mag(px_x1_r));
      DS_ROW_HI: div_dividend = DIV_W'(px_mag(px_y1_r));
      default:   div_dividend = '0;
    endcase
  end

  ttb_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (ts_eff),
    .rsp      (div_rsp)
  );

  // range check
  logic [QUOT_W-1:0] c0, c1, r0, r1, tx_m1, ty_m1;
  logic              empty_x, empty_y;

  always_comb begin
    tx_m1   = tiles_x_r - QUOT_W'(1);
    ty_m1   = tiles_y_r - QUOT_W'(1);
    c0      = px_x0_r[PX_W-1] ? '0 : q_c0_r;
    r0      = px_y0_r[PX_W-1] ? '0 : q_r0_r;
    c1      = px_x1_r[PX_W-1] ? '0 : ((q_c1_r > tx_m1) ? tx_m1 : q_c1_r);
    r1      = px_y1_r[PX_W-1] ? '0 : ((q_r1_r > ty_m1) ? ty_m1 : q_r1_r);
    empty_x = (tiles_x_r == '0) || (px_x1_r[PX_W-1] && (q_c1_r != '0)) || (c0 > c1);
    empty_y = (tiles_y_r == '0) || (px_y1_r[PX_W-1] && (q_r1_r != '0)) || (r0 > r1);
  end

  logic emit, walk_last;

  always_comb begin
    state_nxt         = state_r;
    div_idx_nxt       = div_idx_r;
    px_x0_nxt         = px_x0_r;
    px_x1_nxt         = px_x1_r;
    px_y0_nxt         = px_y0_r;
    px_y1_nxt         = px_y1_r;
    held_triangle_nxt = held_triangle_r;
    tiles_x_nxt       = tiles_x_r;
    tiles_y_nxt       = tiles_y_r;
    q_c0_nxt          = q_c0_r;
    q_r0_nxt          = q_r0_r;
    q_c1_nxt          = q_c1_r;
    q_r1_nxt          = q_r1_r;
    walk_col_nxt      = walk_col_r;
    walk_row_nxt      = walk_row_r;
    col_first_nxt     = col_first_r;
    col_final_nxt     = col_final_r;
    row_final_nxt     = row_final_r;
    row_base_nxt      = row_base_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_tile_nxt      = out_tile_r;
    out_tri_nxt       = out_tri_r;
    out_last_nxt      = out_last_r;
    in_ready          = 1'b0;
    div_start         = 1'b0;
    div_sel           = DS_GRID_X;
    emit              = !out_valid_r || out_ready;
    walk_last         = (walk_col_r == col_final_r) && (walk_row_r == row_final_r);

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          held_triangle_nxt = in_triangle_id;
          px_x0_nxt         = px_floor(xmin);
          px_y0_nxt         = px_floor(ymin);
          px_x1_nxt         = px_ceil(xmax);
          px_y1_nxt         = px_ceil(ymax);
          if (target_present_r) begin
            div_start   = 1'b1;
            div_sel     = DS_GRID_X;
            div_idx_nxt = DS_GRID_X;
            state_nxt   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          unique case (div_idx_r)
            DS_GRID_X: tiles_x_nxt = (div_rsp.quot > MAX_X) ? MAX_X : div_rsp.quot;
            DS_GRID_Y: tiles_y_nxt = (div_rsp.quot > MAX_Y) ? MAX_Y : div_rsp.quot;
            DS_COL_LO: q_c0_nxt = div_rsp.quot;
            DS_ROW_LO: q_r0_nxt = div_rsp.quot;
            DS_COL_HI: q_c1_nxt = div_rsp.quot;
            DS_ROW_HI: q_r1_nxt = div_rsp.quot;
            default: ;
          endcase
          if (div_idx_r == DS_ROW_HI) begin
            state_nxt = ST_CHECK;
          end else begin
            div_start   = 1'b1;
            div_sel     = div_sel_t'(div_idx_r + 3'd1);
            div_idx_nxt = div_sel_t'(div_idx_r + 3'd1);
          end
        end
      end
      ST_CHECK: begin
        if (empty_x || empty_y) begin
          state_nxt = ST_IDLE;
        end else begin
          col_first_nxt = c0[TILE_IDX_W-1:0];
          col_final_nxt = c1[TILE_IDX_W-1:0];
          row_final_nxt = r1[TILE_IDX_W-1:0];
          walk_col_nxt  = c0[TILE_IDX_W-1:0];
          walk_row_nxt  = r0[TILE_IDX_W-1:0];
          row_base_nxt  = TILE_W'(r0[TILE_IDX_W-1:0] * tiles_x_r);
          state_nxt     = ST_WALK;
        end
      end
      ST_WALK: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          out_tile_nxt  = row_base_r + TILE_W'(walk_col_r);
          out_tri_nxt   = held_triangle_r;
          out_last_nxt  = walk_last;
          if (walk_last) begin
            state_nxt = ST_IDLE;
          end else if (walk_col_r == col_final_r) begin
            walk_col_nxt = col_first_r;
            walk_row_nxt = walk_row_r + TILE_IDX_W'(1);
            row_base_nxt = row_base_r + TILE_W'(tiles_x_r);
          end else begin
            walk_col_nxt = walk_col_r + TILE_IDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_idx_r   <= DS_GRID_X;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_idx_r   <= div_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    px_x0_r         <= px_x0_nxt;
    px_x1_r         <= px_x1_nxt;
    px_y0_r         <= px_y0_nxt;
    px_y1_r         <= px_y1_nxt;
    held_triangle_r <= held_triangle_nxt;
    tiles_x_r       <= tiles_x_nxt;
    tiles_y_r       <= tiles_y_nxt;
    q_c0_r          <= q_c0_nxt;
    q_r0_r          <= q_r0_nxt;
    q_c1_r          <= q_c1_nxt;
    q_r1_r          <= q_r1_nxt;
    walk_col_r      <= walk_col_nxt;
    walk_row_r      <= walk_row_nxt;
    col_first_r     <= col_first_nxt;
    col_final_r     <= col_final_nxt;
    row_final_r     <= row_final_nxt;
    row_base_r      <= row_base_nxt;
    out_tile_r      <= out_tile_nxt;
    out_tri_r       <= out_tri_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_tile_index      = out_tile_r;
  assign out_binned_triangle = out_tri_r;
  assign out_last_tile       = out_last_r;

endmodule

`default_nettype wire

// File: rtl/ttb_chk.sv
// ----------------------------------------------------------------------------
// ttb_chk
// Port-level checks of the triangle tile binner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ttb_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ttb_pkg::TILE_W-1:0]   out_tile_index,
  input logic [ttb_pkg::TRI_W-1:0]    out_binned_triangle,
  input logic                         out_last_tile
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tile_index) &&
      $stable(out_binned_triangle) && $stable(out_last_tile))
    else $error("stalled result changed");

  // no new triangle while a walk is unfinished
  a_busy_mid_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_tile |-> !in_ready)
    else $error("input ready in the middle of a walk");

  // idle stays idle without a transaction
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && !in_valid |=> in_ready)
    else $error("left idle without a transaction");

endmodule

bind triangle_tile_binner ttb_chk u_ttb_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_tile_index      (out_tile_index),
  .out_binned_triangle (out_binned_triangle),
  .out_last_tile       (out_last_tile)
);

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle tile binner testbench
// Feeds triangles through the valid/ready input and checks every binned tile
// against a bounding-box binning predictor. A directed table comes first,
// then random triangles under a series of register settings, with random
// idling on both channels.
// ----------------------------------------------------------------------------

module testbench;
  import ttb_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int MAX_X           = 8;
  localparam int MAX_Y           = 8;
  localparam int FRAC            = 4;
  localparam int SETTLE_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DIRECTED_N      = 17;
  localparam int FIXED_N         = 14;
  localparam int PHASES          = 17;
  localparam int ITEMS_PER_PHASE = 18;

  typedef struct packed {
    logic [TRI_W-1:0]   id;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [COORD_W-1:0] x2;
    logic [COORD_W-1:0] y2;
  } triangle_t;

  typedef struct packed {
    logic [TILE_W-1:0] tile;
    logic [TRI_W-1:0]  tri_id;
    logic              last;
  } tile_result_t;

  typedef enum logic [1:0] {
    CHECK_BY_MODEL,
    NO_TILES,
    ONE_TILE
  } row_check_t;

  typedef struct packed {
    triangle_t         shape;
    row_check_t        how;
    logic [TILE_W-1:0] tile;
  } row_t;

  typedef struct packed {
    logic [CFG_W-1:0] ts;
    logic [CFG_W-1:0] sw;
    logic [CFG_W-1:0] sh;
    logic             tp;
  } cfg_set_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [TRI_W-1:0]     in_triangle_id = '0;
  logic [COORD_W-1:0]   in_vert0_x = '0;
  logic [COORD_W-1:0]   in_vert0_y = '0;
  logic [COORD_W-1:0]   in_vert1_x = '0;
  logic [COORD_W-1:0]   in_vert1_y = '0;
  logic [COORD_W-1:0]   in_vert2_x = '0;
  logic [COORD_W-1:0]   in_vert2_y = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [TILE_W-1:0]    out_tile_index;
  logic [TRI_W-1:0]     out_binned_triangle;
  logic                 out_last_tile;

  logic [CFG_W-1:0] tile_size_q;
  logic [CFG_W-1:0] screen_w_q;
  logic [CFG_W-1:0] screen_h_q;
  logic             target_q;

  tile_result_t pending_tiles [$];
  row_t         directed [DIRECTED_N];
  cfg_set_t     fixed_settings [FIXED_N];

  int idle_pct = 15;
  int stall_pct = 65;
  int fail_count = 0;
  int triangles_sent = 0;
  int tiles_checked = 0;
  int quiet_cycles = 0;

  triangle_tile_binner #(
    .MAX_TILES_X    (MAX_X),
    .MAX_TILES_Y    (MAX_Y),
    .COORD_FRAC_BITS(FRAC)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_triangle_id     (in_triangle_id),
    .in_vert0_x         (in_vert0_x),
    .in_vert0_y         (in_vert0_y),
    .in_vert1_x         (in_vert1_x),
    .in_vert1_y         (in_vert1_y),
    .in_vert2_x         (in_vert2_x),
    .in_vert2_y         (in_vert2_y),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_tile_index     (out_tile_index),
    .out_binned_triangle(out_binned_triangle),
    .out_last_tile      (out_last_tile)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void box_bounds(input logic [COORD_W-1:0] a, b, c,
                                     output int lo, output int hi);
    int va, vb, vc;
    va = $signed(a);
    vb = $signed(b);
    vc = $signed(c);
    lo = (va < vb) ? va : vb;
    lo = (lo < vc) ? lo : vc;
    hi = (va > vb) ? va : vb;
    hi = (hi > vc) ? hi : vc;
  endfunction

  // bounding box to tile range, one entry per covered tile, row-major
  function automatic void bin_triangle(triangle_t t);
    int tsz, cols, rows, xmin, xmax, ymin, ymax, c_lo, c_hi, r_lo, r_hi;
    tile_result_t hit;
    if (!target_q) return;
    tsz = (tile_size_q == 0) ? 1 : int'(tile_size_q);
    cols = (int'(screen_w_q) + tsz - 1) / tsz;
    rows = (int'(screen_h_q) + tsz - 1) / tsz;
    if (cols > MAX_X) cols = MAX_X;
    if (rows > MAX_Y) rows = MAX_Y;
    box_bounds(t.x0, t.x1, t.x2, xmin, xmax);
    box_bounds(t.y0, t.y1, t.y2, ymin, ymax);
    c_lo = (xmin >>> FRAC) / tsz;
    r_lo = (ymin >>> FRAC) / tsz;
    c_hi = ((xmax + (1 << FRAC) - 1) >>> FRAC) / tsz;
    r_hi = ((ymax + (1 << FRAC) - 1) >>> FRAC) / tsz;
    if (c_lo < 0) c_lo = 0;
    if (r_lo < 0) r_lo = 0;
    if (c_hi > cols - 1) c_hi = cols - 1;
    if (r_hi > rows - 1) r_hi = rows - 1;
    if (c_lo > c_hi || r_lo > r_hi) return;
    for (int r = r_lo; r <= r_hi; r++) begin
      for (int c = c_lo; c <= c_hi; c++) begin
        hit.tile = TILE_W'(r * cols + c);
        hit.tri_id = t.id;
        hit.last = (r == r_hi && c == c_hi);
        pending_tiles = {pending_tiles, hit};
      end
    end
  endfunction

  function automatic row_t mk_row(logic [TRI_W-1:0] id,
                                  logic [COORD_W-1:0] x0, y0, x1, y1, x2, y2,
                                  row_check_t how, logic [TILE_W-1:0] tile);
    row_t r;
    r.shape = '{id: id, x0: x0, y0: y0, x1: x1, y1: y1, x2: x2, y2: y2};
    r.how = how;
    r.tile = tile;
    return r;
  endfunction

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic logic [COORD_W-1:0] to_fixed(int px);
    int v;
    v = px * (1 << FRAC) + int'($urandom_range(0, (1 << FRAC) - 1));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return COORD_W'(v);
  endfunction

  // mostly triangles around the grid, some small ones, some pure noise
  function automatic triangle_t random_triangle();
    triangle_t t;
    int tsz, lo, hx, hy, cx, cy, spread, sel;
    logic [COORD_W-1:0] xs [3];
    logic [COORD_W-1:0] ys [3];
    sel = $urandom_range(99);
    tsz = (tile_size_q == 0) ? 1 : int'(tile_size_q);
    lo = -(tsz / 2) - 2;
    hx = ((int'(screen_w_q) < MAX_X * tsz) ? int'(screen_w_q) : MAX_X * tsz) + tsz / 2 + 2;
    hy = ((int'(screen_h_q) < MAX_Y * tsz) ? int'(screen_h_q) : MAX_Y * tsz) + tsz / 2 + 2;
    if (lo < -2048) lo = -2048;
    if (hx > 2047) hx = 2047;
    if (hy > 2047) hy = 2047;
    cx = pick(lo, hx);
    cy = pick(lo, hy);
    spread = $urandom_range(1, 2 * tsz);
    for (int i = 0; i < 3; i++) begin
      if (sel < 50) begin
        xs[i] = to_fixed(cx + pick(-spread, spread));
        ys[i] = to_fixed(cy + pick(-spread, spread));
      end else if (sel < 85) begin
        xs[i] = to_fixed(pick(lo, hx));
        ys[i] = to_fixed(pick(lo, hy));
      end else begin
        xs[i] = COORD_W'($urandom);
        ys[i] = COORD_W'($urandom);
      end
    end
    t.id = TRI_W'($urandom);
    t.x0 = xs[0];
    t.y0 = ys[0];
    t.x1 = xs[1];
    t.y1 = ys[1];
    t.x2 = xs[2];
    t.y2 = ys[2];
    return t;
  endfunction

  task automatic send_triangle(triangle_t t, row_check_t how, logic [TILE_W-1:0] tile_no);
    int gap;
    tile_result_t hit;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_triangle_id <= t.id;
    in_vert0_x <= t.x0;
    in_vert0_y <= t.y0;
    in_vert1_x <= t.x1;
    in_vert1_y <= t.y1;
    in_vert2_x <= t.x2;
    in_vert2_y <= t.y2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    triangles_sent++;
    case (how)
      CHECK_BY_MODEL: bin_triangle(t);
      ONE_TILE: begin
        hit = '{tile: tile_no, tri_id: t.id, last: 1'b1};
        pending_tiles = {pending_tiles, hit};
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_tiles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(cfg_set_t s);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [CFG_W-1:0]     vals [4];
    idx = '{CFG_TILE_SIZE, CFG_SCREEN_WIDTH, CFG_SCREEN_HEIGHT, CFG_TARGET};
    vals = '{s.ts, s.sw, s.sh, CFG_W'(s.tp)};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    tile_size_q = s.ts;
    screen_w_q = s.sw;
    screen_h_q = s.sh;
    target_q = s.tp;
  endtask

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin : tile_monitor
    tile_result_t want;
    if (rst_n && out_valid && out_ready) begin
      tiles_checked++;
      if (pending_tiles.size() == 0) begin
        $display("%0t: unexpected tile transaction: tile %0d triangle %0h last %0b",
                 $time, out_tile_index, out_binned_triangle, out_last_tile);
        fail_count++;
      end else begin
        want = pending_tiles.pop_front();
        if (out_tile_index !== want.tile) begin
          $display("%0t: tile_index expected %0d actual %0d",
                   $time, want.tile, out_tile_index);
          fail_count++;
        end
        if (out_binned_triangle !== want.tri_id) begin
          $display("%0t: binned_triangle expected %0h actual %0h",
                   $time, want.tri_id, out_binned_triangle);
          fail_count++;
        end
        if (out_last_tile !== want.last) begin
          $display("%0t: last_tile expected %0b actual %0b",
                   $time, want.last, out_last_tile);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("triangle_tile_binner test failed");
        $finish;
      end
    end
  end

  initial begin
    cfg_set_t s;
    tile_size_q = TILE_SIZE_RST;
    screen_w_q = SCREEN_WIDTH_RST;
    screen_h_q = SCREEN_HEIGHT_RST;
    target_q = 1'b1;

    // reset register values, 8 x 8 grid of 64 pixel tiles
    directed[0]  = mk_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                          16'h0000, 16'h0000, ONE_TILE, 6'd0);
    directed[1]  = mk_row(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                          16'h7fff, 16'h7fff, NO_TILES, 6'd0);
    directed[2]  = mk_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                          16'h8000, 16'h8000, NO_TILES, 6'd0);
    directed[3]  = mk_row(16'h0001, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                          16'h0000, 16'h0000, CHECK_BY_MODEL, 6'd0);
    directed[4]  = mk_row(16'h0002, 16'hfff8, 16'hfff8, 16'hfff8, 16'hfff8,
                          16'hfff8, 16'hfff8, ONE_TILE, 6'd0);
    directed[5]  = mk_row(16'h0003, 16'd1024, 16'd1024, 16'd1024, 16'd1024,
                          16'd1024, 16'd1024, ONE_TILE, 6'd9);
    directed[6]  = mk_row(16'h0004, 16'd8176, 16'd8176, 16'd8176, 16'd8176,
                          16'd8176, 16'd8176, ONE_TILE, 6'd63);
    directed[7]  = mk_row(16'h0005, 16'd8192, 16'd0, 16'd8192, 16'd0,
                          16'd8192, 16'd0, NO_TILES, 6'd0);
    directed[8]  = mk_row(16'h0006, 16'd1016, 16'd0, 16'd1032, 16'd0,
                          16'd1016, 16'd0, CHECK_BY_MODEL, 6'd0);
    directed[9]  = mk_row(16'h0007, 16'd0, 16'd0, 16'd1024, 16'd0,
                          16'd512, 16'd0, CHECK_BY_MODEL, 6'd0);
    directed[10] = mk_row(16'h0008, 16'd3000, 16'd2000, 16'd6000, 16'd500,
                          16'd100, 16'd7000, CHECK_BY_MODEL, 6'd0);
    // boxes above the screen still truncate into row 0
    directed[11] = mk_row(16'h0009, 16'd100, 16'hfc18, 16'd100, 16'hfc18,
                          16'd100, 16'hfc18, ONE_TILE, 6'd0);
    directed[12] = mk_row(16'h000a, 16'd100, 16'hbb40, 16'd100, 16'hbb40,
                          16'd100, 16'hbb40, NO_TILES, 6'd0);
    directed[13] = mk_row(16'h000b, 16'd3000, 16'd0, 16'd3000, 16'h7fff,
                          16'd3000, 16'd0, CHECK_BY_MODEL, 6'd0);
    directed[14] = mk_row(16'h000c, 16'h8000, 16'd5000, 16'h7fff, 16'd5000,
                          16'd0, 16'd5000, CHECK_BY_MODEL, 6'd0);
    directed[15] = mk_row(16'h5a5a, 16'h7fff, 16'd0, 16'd0, 16'd0,
                          16'd0, 16'd0, CHECK_BY_MODEL, 6'd0);
    directed[16] = mk_row(16'hffff, 16'd8191, 16'd8191, 16'd8191, 16'd8191,
                          16'd8191, 16'd8191, ONE_TILE, 6'd63);

    fixed_settings[0]  = '{12'd64, 12'd512, 12'd512, 1'b1};
    fixed_settings[1]  = '{12'd1, 12'd8, 12'd8, 1'b1};
    fixed_settings[2]  = '{12'd0, 12'd5, 12'd3, 1'b1};
    fixed_settings[3]  = '{12'd2048, 12'd2048, 12'd2048, 1'b1};
    fixed_settings[4]  = '{12'd4095, 12'd4095, 12'd4095, 1'b1};
    fixed_settings[5]  = '{12'd64, 12'd0, 12'd512, 1'b1};
    fixed_settings[6]  = '{12'd64, 12'd512, 12'd0, 1'b1};
    fixed_settings[7]  = '{12'd64, 12'd512, 12'd512, 1'b0};
    fixed_settings[8]  = '{12'd100, 12'd700, 12'd300, 1'b1};
    fixed_settings[9]  = '{12'd16, 12'd100, 12'd2048, 1'b1};
    fixed_settings[10] = '{12'd256, 12'd1, 12'd1, 1'b1};
    fixed_settings[11] = '{12'd32, 12'd256, 12'd256, 1'b1};
    fixed_settings[12] = '{12'd0, 12'd0, 12'd0, 1'b0};
    fixed_settings[13] = '{12'd1, 12'd4095, 12'd4095, 1'b1};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_N; i++) begin
      send_triangle(directed[i].shape, directed[i].how, directed[i].tile);
    end
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 6) begin
        idle_pct = 65;
        stall_pct = 15;
      end
      if (p == 12) begin
        idle_pct = 0;
        stall_pct = 0;
      end
      if (p < FIXED_N) begin
        s = fixed_settings[p];
      end else begin
        s.ts = CFG_W'($urandom_range(1, 256));
        s.sw = CFG_W'($urandom_range(1, 2048));
        s.sh = CFG_W'($urandom_range(1, 2048));
        s.tp = ($urandom_range(9) != 0);
      end
      apply_config(s);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_triangle(random_triangle(), CHECK_BY_MODEL, '0);
      end
      drain();
    end

    $display("%0d triangles binned into %0d checked tile transactions", triangles_sent,
             tiles_checked);
    $display("%0d register settings, zero and maximum sizes and an unbound target among them",
             PHASES + 1);
    if (fail_count == 0) begin
      $display("triangle_tile_binner test passed");
    end else begin
      $display("triangle_tile_binner test failed");
    end
    $finish;
  end

endmodule
